/* hw/rtl/gfbi_pkg.sv */
// shared types, constants and helpers for the grid field bilinear interpolator
// no dependencies; used by gfbi_bank, gfbi_axis and grid_field_bilinear_interp in hw/rtl
package gfbi_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int IDX_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
  // four banks split by column and row parity, each holds a quarter of the grid
  localparam int BANK_AW  = (COL_W - 1) + (ROW_W - 1);
  localparam int BANK_N   = 4;
  localparam int USED_W   = 7;
  localparam int FRAC_W   = 16;
  localparam int KEEP_W   = IDX_W + FRAC_W;
  localparam int COMP_N   = 3;
  localparam int PADDR_W  = 5;

  // result queue, sized to cover the pipeline latency plus the ready loop
  localparam int QDEPTH   = 16;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = QPTR_W + 1;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_SCALE_X  = 3'd2,
    REG_SCALE_Y  = 3'd3,
    REG_COLS     = 3'd4,
    REG_ROWS     = 3'd5,
    REG_MIRROR_X = 3'd6,
    REG_MIRROR_Y = 3'd7
  } reg_idx_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // component 0 is x, 1 is y, 2 is z
  typedef logic [COMP_N-1:0][31:0] field_t;

  typedef struct packed {
    logic              in_grid;
    logic [IDX_W-1:0]  idx;
    logic [FRAC_W:0]   frac;
  } axis_res_t;

  typedef struct packed {
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bz;
    logic        in_grid;
  } result_t;

  function automatic logic [USED_W-1:0] clamp_used(input logic [USED_W-1:0] n,
                                                   input logic [USED_W-1:0] maxv);
    logic [USED_W-1:0] r;
    begin
      r = n;
      if (n < USED_W'(2)) r = USED_W'(2);
      else if (n > maxv) r = maxv;
      return r;
    end
  endfunction

endpackage

/* hw/rtl/gfbi_in_if.sv */
// input channel of the interpolator: load or query item with valid/ready
// depends on nothing
interface gfbi_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic [5:0]         cell_col;
  logic [5:0]         cell_row;
  logic signed [31:0] load_bx;
  logic signed [31:0] load_by;
  logic signed [31:0] load_bz;

  modport source (output valid, func, coord_x, coord_y, cell_col, cell_row,
                  load_bx, load_by, load_bz, input ready);
  modport sink (input valid, func, coord_x, coord_y, cell_col, cell_row,
                load_bx, load_by, load_bz, output ready);
endinterface

/* hw/rtl/gfbi_out_if.sv */
// result channel of the interpolator: interpolated field with valid/ready
// depends on nothing
interface gfbi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_bx;
  logic signed [31:0] out_by;
  logic signed [31:0] out_bz;
  logic               inside_res;

  modport source (output valid, out_bx, out_by, out_bz, inside_res, input ready);
  modport sink (input valid, out_bx, out_by, out_bz, inside_res, output ready);
endinterface

/* hw/rtl/gfbi_bank.sv */
// one grid bank: synchronous memory with one write and one registered read port
// depends on gfbi_pkg
module gfbi_bank import gfbi_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [BANK_AW-1:0] waddr,
  input  field_t             wdata,
  input  logic [BANK_AW-1:0] raddr,
  output field_t             rdata
);

  field_t mem [2**BANK_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/gfbi_axis.sv */
// one axis of the position pipeline: offset, scale, range check, mirror, edge clamp
// depends on gfbi_pkg; coord passes the ud1, product and pos3 registers before res
module gfbi_axis import gfbi_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] coord,
  input  logic signed [31:0] origin,
  input  logic [31:0]        scale,
  input  logic [USED_W-1:0]  used,
  input  logic               mirror,
  output axis_res_t          res
);

  logic signed [32:0] diff;
  logic               neg1, neg2;
  logic [31:0]        ud1;
  logic [47:0]        prod_hi2;
  logic [31:0]        prod_lo2;
  logic [47:0]        lo_full;
  logic [48:0]        pos;
  logic [USED_W-1:0]  used_m1;
  logic [KEEP_W-1:0]  limit;
  logic               inside3;
  logic [KEEP_W-1:0]  pos3;
  logic [KEEP_W-1:0]  mpos;

  assign diff    = {coord[31], coord} - {origin[31], origin};
  assign lo_full = 48'(ud1[15:0]) * 48'(scale);
  assign pos     = {1'b0, prod_hi2} + 49'(prod_lo2);
  assign used_m1 = used - USED_W'(1);
  assign limit   = {used_m1[IDX_W-1:0], {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    neg1     <= diff[32];
    ud1      <= diff[31:0];
    neg2     <= neg1;
    prod_hi2 <= 48'(ud1[31:16]) * 48'(scale);
    prod_lo2 <= lo_full[47:16];
    inside3  <= !neg2 && (pos <= 49'(limit));
    pos3     <= pos[KEEP_W-1:0];
  end

  always_comb begin
    mpos        = mirror ? (limit - pos3) : pos3;
    res.in_grid = inside3;
    res.idx     = mpos[KEEP_W-1:FRAC_W];
    res.frac    = {1'b0, mpos[FRAC_W-1:0]};
    // upper edge: step back one cell and take the full far weight
    if (USED_W'(mpos[KEEP_W-1:FRAC_W]) >= used_m1) begin
      res.idx  = IDX_W'(used - USED_W'(2));
      res.frac = {1'b1, {FRAC_W{1'b0}}};
    end
  end

endmodule

/* hw/rtl/grid_field_bilinear_interp.sv */
// top level of the grid field bilinear interpolator
// depends on gfbi_pkg, gfbi_in_if, gfbi_out_if, gfbi_axis and gfbi_bank
//
// The block holds a 64 x 64 grid of three-component field vectors and answers
// point queries by bilinear interpolation. A load item (func 0) writes one cell
// and gives no result; a query item (func 1) gives exactly one result, zero with
// inside_res clear when the point lies off the grid. Items are taken one per
// cycle while input ready is high, loads and queries mixed freely. A query
// passes the input register, the position pipelines, the bank read and
// the weight, product and sum stages with no stall. The grid is kept
// in four banks split by column and row parity, so the four neighbours of any
// query come from four different banks in one read cycle; loads write at the
// same pipeline stage where queries read, so a query always sees every load
// accepted before it with no forwarding needed. Results go into a sixteen-entry
// queue; input ready drops only when sixteen queries are accepted and not yet
// delivered, so a stalled output side holds up the input only after that. The
// grid comes up unwritten after reset and has no clearing pass: every cell a
// query reaches must be loaded first. Configuration sits on an APB-style port,
// register i at byte address 4*i, and must be written while no item is in flight.
module grid_field_bilinear_interp import gfbi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  gfbi_in_if.sink            in,
  gfbi_out_if.source         out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic signed [31:0] origin_x, origin_y;
  logic [31:0]        scale_x, scale_y;
  logic [USED_W-1:0]  columns_used, rows_used;
  logic               mirror_x, mirror_y;
  logic [USED_W-1:0]  cols_eff, rows_eff;
  reg_idx_t           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      scale_x      <= 32'h0001_0000;
      scale_y      <= 32'h0001_0000;
      columns_used <= USED_W'(MAX_COLS);
      rows_used    <= USED_W'(MAX_ROWS);
      mirror_x     <= 1'b0;
      mirror_y     <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_ORIGIN_X: origin_x     <= pwdata;
        REG_ORIGIN_Y: origin_y     <= pwdata;
        REG_SCALE_X:  scale_x      <= pwdata;
        REG_SCALE_Y:  scale_y      <= pwdata;
        REG_COLS:     columns_used <= pwdata[USED_W-1:0];
        REG_ROWS:     rows_used    <= pwdata[USED_W-1:0];
        REG_MIRROR_X: mirror_x     <= pwdata[0];
        REG_MIRROR_Y: mirror_y     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ORIGIN_X: prdata = origin_x;
      REG_ORIGIN_Y: prdata = origin_y;
      REG_SCALE_X:  prdata = scale_x;
      REG_SCALE_Y:  prdata = scale_y;
      REG_COLS:     prdata = 32'(columns_used);
      REG_ROWS:     prdata = 32'(rows_used);
      REG_MIRROR_X: prdata = 32'(mirror_x);
      REG_MIRROR_Y: prdata = 32'(mirror_y);
      default:      prdata = '0;
    endcase
  end

  // used counts outside 2..max behave as the nearest legal count
  assign cols_eff = clamp_used(columns_used, USED_W'(MAX_COLS));
  assign rows_eff = clamp_used(rows_used, USED_W'(MAX_ROWS));

  // credit for the result queue: queries accepted and not yet delivered
  logic [QCNT_W-1:0] reserved, reserved_next;
  logic              in_acc, q_acc, out_acc;

  assign in.ready = (reserved < QCNT_W'(QDEPTH));
  assign in_acc   = in.valid && in.ready;
  assign q_acc    = in_acc && (in.func == FUNC_QUERY);
  assign out_acc  = out.valid && out.ready;

  always_comb begin
    reserved_next = reserved;
    if (q_acc && !out_acc) reserved_next = reserved + QCNT_W'(1);
    else if (!q_acc && out_acc) reserved_next = reserved - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) reserved <= '0;
    else reserved <= reserved_next;
  end

  // stage 0: input register
  logic               q0, ld0;
  logic signed [31:0] cx0, cy0;
  logic [5:0]         col0, row0;
  field_t             ldat0;

  always_ff @(posedge clk) begin
    if (rst) begin
      q0  <= 1'b0;
      ld0 <= 1'b0;
    end else begin
      q0  <= q_acc;
      ld0 <= in_acc && (in.func == FUNC_LOAD);
    end
    cx0   <= in.coord_x;
    cy0   <= in.coord_y;
    col0  <= in.cell_col;
    row0  <= in.cell_row;
    ldat0 <= {in.load_bz, in.load_by, in.load_bx};
  end

  // stages 1-3: position pipelines, load data rides alongside
  axis_res_t resx, resy;

  gfbi_axis u_axis_x (
    .clk(clk), .coord(cx0), .origin(origin_x), .scale(scale_x),
    .used(cols_eff), .mirror(mirror_x), .res(resx)
  );

  gfbi_axis u_axis_y (
    .clk(clk), .coord(cy0), .origin(origin_y), .scale(scale_y),
    .used(rows_eff), .mirror(mirror_y), .res(resy)
  );

  logic [3:1]  q_d, ld_d;
  logic [5:0]  col_d [3:1];
  logic [5:0]  row_d [3:1];
  field_t      ldat_d [3:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_d  <= '0;
      ld_d <= '0;
    end else begin
      q_d  <= {q_d[2:1], q0};
      ld_d <= {ld_d[2:1], ld0};
    end
    col_d[1]  <= col0;
    row_d[1]  <= row0;
    ldat_d[1] <= ldat0;
    for (int s = 2; s <= 3; s++) begin
      col_d[s]  <= col_d[s-1];
      row_d[s]  <= row_d[s-1];
      ldat_d[s] <= ldat_d[s-1];
    end
  end

  // stage 3: bank addressing; loads write and queries read here
  logic [IDX_W-1:0]   ix1, iy1;
  logic [COL_W-2:0]   ca_even, ca_odd;
  logic [ROW_W-2:0]   ra_even, ra_odd;
  logic [BANK_AW-1:0] raddr [BANK_N];
  logic [BANK_AW-1:0] waddr;
  logic [BANK_N-1:0]  we;
  field_t             rdata [BANK_N];

  assign ix1     = resx.idx + IDX_W'(1);
  assign iy1     = resy.idx + IDX_W'(1);
  // the even neighbour sits at (i+1)/2, the odd one at i/2
  assign ca_even = ix1[COL_W-1:1];
  assign ca_odd  = resx.idx[COL_W-1:1];
  assign ra_even = iy1[ROW_W-1:1];
  assign ra_odd  = resy.idx[ROW_W-1:1];
  assign waddr   = {row_d[3][ROW_W-1:1], col_d[3][COL_W-1:1]};

  for (genvar b = 0; b < BANK_N; b++) begin : g_bank
    localparam logic PC = b[0];
    localparam logic PR = b[1];
    assign raddr[b] = {(PR ? ra_odd : ra_even), (PC ? ca_odd : ca_even)};
    assign we[b]    = ld_d[3] && (row_d[3][0] == PR) && (col_d[3][0] == PC);
    gfbi_bank u_bank (
      .clk(clk), .we(we[b]), .waddr(waddr), .wdata(ldat_d[3]),
      .raddr(raddr[b]), .rdata(rdata[b])
    );
  end

  // stage 4: fractions wait for the bank read
  logic             q4, in4, px4, py4;
  logic [FRAC_W:0]  fx4, fy4;

  always_ff @(posedge clk) begin
    if (rst) q4 <= 1'b0;
    else q4 <= q_d[3];
    in4 <= resx.in_grid && resy.in_grid;
    px4 <= resx.idx[0];
    py4 <= resy.idx[0];
    fx4 <= resx.frac;
    fy4 <= resy.frac;
  end

  // stage 5: corner weights, neighbour order 00, 10, 01, 11
  logic [FRAC_W:0] wx0, wy0;
  logic            q5, in5, px5, py5;
  logic [32:0]     w5 [4];
  field_t          data5 [BANK_N];

  assign wx0 = {1'b1, {FRAC_W{1'b0}}} - fx4;
  assign wy0 = {1'b1, {FRAC_W{1'b0}}} - fy4;

  always_ff @(posedge clk) begin
    if (rst) q5 <= 1'b0;
    else q5 <= q4;
    in5   <= in4;
    px5   <= px4;
    py5   <= py4;
    w5[0] <= 33'(34'(wx0) * 34'(wy0));
    w5[1] <= 33'(34'(fx4) * 34'(wy0));
    w5[2] <= 33'(34'(wx0) * 34'(fy4));
    w5[3] <= 33'(34'(fx4) * 34'(fy4));
    for (int b = 0; b < BANK_N; b++) data5[b] <= rdata[b];
  end

  // stage 6: value times weight, one product per component and corner
  logic               q6, in6;
  logic signed [65:0] p6 [COMP_N][4];

  always_ff @(posedge clk) begin
    if (rst) q6 <= 1'b0;
    else q6 <= q5;
    in6 <= in5;
    for (int c = 0; c < COMP_N; c++) begin
      for (int n = 0; n < 4; n++) begin
        p6[c][n] <= $signed(data5[{py5 ^ n[1], px5 ^ n[0]}][c]) *
                    $signed({1'b0, w5[n]});
      end
    end
  end

  // stage 7: exact sum plus half for round half up
  logic               q7, in7;
  logic signed [67:0] sum7 [COMP_N];

  always_ff @(posedge clk) begin
    if (rst) q7 <= 1'b0;
    else q7 <= q6;
    in7 <= in6;
    for (int c = 0; c < COMP_N; c++) begin
      sum7[c] <= 68'(p6[c][0]) + 68'(p6[c][1]) + 68'(p6[c][2]) + 68'(p6[c][3])
                 + 68'sh8000_0000;
    end
  end

  // stage 8: drop the 32 weight fraction bits, saturate, zero when outside
  logic signed [35:0] shr [COMP_N];
  logic [31:0]        sat [COMP_N];
  result_t            res_push;

  always_comb begin
    for (int c = 0; c < COMP_N; c++) begin
      shr[c] = sum7[c][67:32];
      if (shr[c] > 36'sh0_7FFF_FFFF) sat[c] = 32'h7FFF_FFFF;
      else if (shr[c] < -36'sh0_8000_0000) sat[c] = 32'h8000_0000;
      else sat[c] = shr[c][31:0];
      if (!in7) sat[c] = '0;
    end
    res_push.bx      = sat[0];
    res_push.by      = sat[1];
    res_push.bz      = sat[2];
    res_push.in_grid = in7;
  end

  // result queue
  result_t           fifo [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q7) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (out_acc) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (q7 && !out_acc) count <= count + QCNT_W'(1);
      else if (!q7 && out_acc) count <= count - QCNT_W'(1);
    end
    if (q7) fifo[wr_ptr] <= res_push;
  end

  assign out.valid      = (count != '0);
  assign out.out_bx     = fifo[rd_ptr].bx;
  assign out.out_by     = fifo[rd_ptr].by;
  assign out.out_bz     = fifo[rd_ptr].bz;
  assign out.inside_res = fifo[rd_ptr].in_grid;

  // the credit count keeps the queue from ever overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == QCNT_W'(QDEPTH)) |-> !q7)
    else $error("result queue overflow");

  // queued results are always covered by credits
  a_credit_cover: assert property (@(posedge clk) disable iff (rst)
    count <= reserved)
    else $error("queue holds more results than credits");

  // an accepted query always reaches the queue write stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    q_acc |-> ##8 q7)
    else $error("query lost in the pipeline");

  // load and query never share the bank access stage
  a_bank_stage: assert property (@(posedge clk) disable iff (rst)
    !(ld_d[3] && q_d[3]))
    else $error("load and query collide at bank access");

  // an off-grid point gives an all-zero field
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (q7 && !in7) |-> (res_push.bx == '0 && res_push.by == '0 && res_push.bz == '0))
    else $error("outside result not zero");

endmodule

/* verif/grid_field_bilinear_interp_test.sv */
// self-checking testbench for the grid field bilinear interpolator
// depends on gfbi_pkg, gfbi_in_if, gfbi_out_if and grid_field_bilinear_interp
module grid_field_bilinear_interp_test import gfbi_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // holds interpolated fields still owed by the block, oldest first
  class field_result_board;
    result_t owed[$];
    int errors;

    function void note(result_t r);
      owed.push_back(r);
    endfunction

    function void check(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.bx !== want.bx) begin
        $display("%0t: out_bx expected %h actual %h", $realtime, want.bx, got.bx);
        errors++;
      end
      if (got.by !== want.by) begin
        $display("%0t: out_by expected %h actual %h", $realtime, want.by, got.by);
        errors++;
      end
      if (got.bz !== want.bz) begin
        $display("%0t: out_bz expected %h actual %h", $realtime, want.bz, got.bz);
        errors++;
      end
      if (got.in_grid !== want.in_grid) begin
        $display("%0t: inside_res expected %b actual %b", $realtime, want.in_grid,
                 got.in_grid);
        errors++;
      end
    endfunction
  endclass

  typedef struct {
    logic        func;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [31:0] b [COMP_N];
  } grid_item_t;

  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  gfbi_in_if  in_ch ();
  gfbi_out_if out_ch ();

  grid_field_bilinear_interp dut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  field_result_board board = new();

  // shadow of the grid and of the registers
  logic [31:0] grid_mem [COMP_N][MAX_COLS*MAX_ROWS];
  logic signed [31:0] org_x, org_y;
  logic [31:0] scl_x, scl_y;
  logic [USED_W-1:0] ncols, nrows;
  logic mir_x, mir_y;
  bit stall_on;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_field_bilinear_interp: mismatch");
      $finish;
    end
  end

  // used counts below two act as two, above the grid size as the grid size
  function automatic int used_of(logic [USED_W-1:0] n, int maxv);
    if (n < 2) return 2;
    if (n > maxv) return maxv;
    return n;
  endfunction

  // maps a coordinate to a cell index and a Q1.16 fraction, 0 if off the grid
  function automatic bit axis_map(logic signed [31:0] c, logic signed [31:0] org,
                                  logic [31:0] sc, int used, logic mir,
                                  output int idx, output longint frac);
    longint d, pos, lim, s;
    d = longint'(c) - longint'(org);
    s = longint'({32'b0, sc});
    if (d < 0) return 0;
    pos = (d >> 16) * s + (((d & 64'hFFFF) * s) >> 16);
    lim = longint'(used - 1) << 16;
    if (pos > lim) return 0;
    if (mir) pos = lim - pos;
    idx = int'(pos >> 16);
    frac = pos & 64'hFFFF;
    // upper edge: clamp to the last pair and take the far cell whole
    if (idx >= used - 1) begin
      idx = used - 2;
      frac = 65536;
    end
    return 1;
  endfunction

  // weighted sum of four cells, rounded half up
  function automatic logic [31:0] blend4(logic [31:0] v00, logic [31:0] v10,
                                         logic [31:0] v01, logic [31:0] v11,
                                         longint fx, longint fy);
    longint s, r;
    s = longint'($signed(v00)) * ((65536 - fx) * (65536 - fy))
      + longint'($signed(v10)) * (fx * (65536 - fy))
      + longint'($signed(v01)) * ((65536 - fx) * fy)
      + longint'($signed(v11)) * (fx * fy);
    r = (s + 64'sd2147483648) >>> 32;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // applies one accepted item to the shadow grid or predicts its field
  function automatic void predict_item(grid_item_t it);
    result_t r;
    int ix, iy, a;
    longint fx, fy;
    if (it.func == FUNC_LOAD) begin
      for (int k = 0; k < COMP_N; k++)
        grid_mem[k][int'(it.row) * MAX_COLS + int'(it.col)] = it.b[k];
      return;
    end
    r = '0;
    if (axis_map(it.cx, org_x, scl_x, used_of(ncols, MAX_COLS), mir_x, ix, fx) &&
        axis_map(it.cy, org_y, scl_y, used_of(nrows, MAX_ROWS), mir_y, iy, fy)) begin
      a = iy * MAX_COLS + ix;
      r.bx = blend4(grid_mem[0][a], grid_mem[0][a+1], grid_mem[0][a+MAX_COLS],
                    grid_mem[0][a+MAX_COLS+1], fx, fy);
      r.by = blend4(grid_mem[1][a], grid_mem[1][a+1], grid_mem[1][a+MAX_COLS],
                    grid_mem[1][a+MAX_COLS+1], fx, fy);
      r.bz = blend4(grid_mem[2][a], grid_mem[2][a+1], grid_mem[2][a+MAX_COLS],
                    grid_mem[2][a+MAX_COLS+1], fx, fy);
      r.in_grid = 1'b1;
    end
    board.note(r);
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!stall_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(grid_item_t it);
    int g;
    in_ch.valid    <= 1'b1;
    in_ch.func     <= it.func;
    in_ch.coord_x  <= it.cx;
    in_ch.coord_y  <= it.cy;
    in_ch.cell_col <= it.col;
    in_ch.cell_row <= it.row;
    in_ch.load_bx  <= it.b[0];
    in_ch.load_by  <= it.b[1];
    in_ch.load_bz  <= it.b[2];
    do @(posedge clk); while (!in_ch.ready);
    predict_item(it);
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load_cell(int col, int row, logic [31:0] bx, logic [31:0] by,
                           logic [31:0] bz);
    grid_item_t it;
    it.func = FUNC_LOAD;
    it.cx = $urandom;
    it.cy = $urandom;
    it.col = col;
    it.row = row;
    it.b[0] = bx;
    it.b[1] = by;
    it.b[2] = bz;
    send_item(it);
  endtask

  task automatic query_at(logic [31:0] cx, logic [31:0] cy);
    grid_item_t it;
    it.func = FUNC_QUERY;
    it.cx = cx;
    it.cy = cy;
    it.col = $urandom;
    it.row = $urandom;
    for (int k = 0; k < COMP_N; k++) it.b[k] = $urandom;
    send_item(it);
  endtask

  // setup cycle then access cycle; the register takes the value at the end of the access cycle
  task automatic reg_write(reg_idx_t r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_ORIGIN_X: org_x = v;
      REG_ORIGIN_Y: org_y = v;
      REG_SCALE_X:  scl_x = v;
      REG_SCALE_Y:  scl_y = v;
      REG_COLS:     ncols = v[USED_W-1:0];
      REG_ROWS:     nrows = v[USED_W-1:0];
      REG_MIRROR_X: mir_x = v[0];
      REG_MIRROR_Y: mir_y = v[0];
      default: ;
    endcase
  endtask

  // a load in flight gives no result, so after the last result wait out the pipe
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] sx,
                            logic [31:0] sy, logic [31:0] nc, logic [31:0] nr,
                            logic [31:0] mx, logic [31:0] my);
    settle();
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_SCALE_X, sx);
    reg_write(REG_SCALE_Y, sy);
    reg_write(REG_COLS, nc);
    reg_write(REG_ROWS, nr);
    reg_write(REG_MIRROR_X, mx);
    reg_write(REG_MIRROR_Y, my);
  endtask

  // a coordinate that mostly lands on the grid, sometimes just past its edges
  function automatic logic [31:0] coord_near(logic signed [31:0] org, logic [31:0] sc,
                                             int used);
    longint span, off, c;
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return $urandom;
    if (sc == 0) span = 64'h7FFF_FFFF;
    else span = (longint'(used - 1) << 32) / longint'({32'b0, sc});
    if (span > 64'h1_FFFF_FFFF) span = 64'h1_FFFF_FFFF;
    if (pick == 1) off = span;
    else if (pick == 2) off = span + $urandom_range(1, 3);
    else if (pick == 3) off = -longint'($urandom_range(1, 3));
    else off = ((longint'($urandom) << 16) ^ longint'($urandom)) % (span + 1);
    c = longint'(org) + off;
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c[31:0];
  endfunction

  // field values: mostly random, sometimes the extremes
  function automatic logic [31:0] field_val();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        load_cell($urandom_range(0, 63), $urandom_range(0, 63), field_val(),
                  field_val(), field_val());
      end else begin
        query_at(coord_near(org_x, scl_x, used_of(ncols, MAX_COLS)),
                 coord_near(org_y, scl_y, used_of(nrows, MAX_ROWS)));
      end
    end
  endtask

  // result side: ready in bursts with random stalls between
  initial begin
    int n, g;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      n = $urandom_range(1, 8);
      out_ch.ready <= 1'b1;
      repeat (n) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // compare every delivered item against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.bx = out_ch.out_bx;
      got.by = out_ch.out_by;
      got.bz = out_ch.out_bz;
      got.in_grid = out_ch.inside_res;
      board.check(got);
    end
  end

  initial begin
    cycles = 0;
    stall_on = 1'b1;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_LOAD;
    in_ch.coord_x <= '0;
    in_ch.coord_y <= '0;
    in_ch.cell_col <= '0;
    in_ch.cell_row <= '0;
    in_ch.load_bx <= '0;
    in_ch.load_by <= '0;
    in_ch.load_bz <= '0;
    org_x = 0;
    org_y = 0;
    scl_x = 32'd65536;
    scl_y = 32'd65536;
    ncols = 7'd64;
    nrows = 7'd64;
    mir_x = 1'b0;
    mir_y = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // the grid comes up unwritten, so fill every cell before any query
    stall_on = 1'b0;
    for (int r = 0; r < MAX_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++)
        load_cell(c, r, $urandom, $urandom, $urandom);
    stall_on = 1'b1;

    // directed: field extremes in the corners, origin, upper edge, off grid
    load_cell(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    load_cell(63, 63, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    load_cell(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    query_at(32'h0, 32'h0);
    query_at(32'h0000_8000, 32'h0000_8000);
    query_at(32'h003F_0000, 32'h003F_0000);
    query_at(32'h003F_0001, 32'h0);
    query_at(32'h0, 32'h003F_0001);
    query_at(32'hFFFF_FFFF, 32'h0);
    query_at(32'h7FFF_FFFF, 32'h8000_0000);
    query_at(32'h003E_FFFF, 32'h0000_FFFF);

    // zero scale: everything at or above the origin maps to cell zero
    set_config(32'h8000_0000, 32'hFFFF_0000, 32'h0, 32'h0, 64, 64, 0, 0);
    query_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query_at(32'h8000_0000, 32'hFFFE_FFFF);
    random_items(60);

    // used counts under two, mirrored axes
    set_config(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 0, 1, 1, 1);
    query_at(32'h0, 32'h0001_0000);
    query_at(32'h0001_0000, 32'h0);
    random_items(60);

    // largest scale, used counts above the grid, x origin at the top, y at the bottom
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 127, 65,
               1, 0);
    random_items(60);

    // random settings, some phases with no idling on either side
    for (int p = 0; p < 12; p++) begin
      set_config($urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 2000000))
                 - 1000000,
                 $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 2000000))
                 - 1000000,
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1024, 2000000),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1024, 2000000),
                 $urandom_range(0, 127), $urandom_range(0, 127),
                 $urandom_range(0, 1), $urandom_range(0, 1));
      stall_on = (p % 4 != 3);
      random_items(85);
    end
    stall_on = 1'b1;

    in_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("grid_field_bilinear_interp: match");
    end else begin
      $display("grid_field_bilinear_interp: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/gfbi_pkg.sv
hw/rtl/gfbi_in_if.sv
hw/rtl/gfbi_out_if.sv
hw/rtl/gfbi_bank.sv
hw/rtl/gfbi_axis.sv
hw/rtl/grid_field_bilinear_interp.sv
verif/grid_field_bilinear_interp_test.sv
